// ----- design/assert_macros.svh -----
// Assertion macros used by the parser back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define DTOI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define DTOI_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define DTOI_ASSERT(label, clk, rst, prop)
`define DTOI_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- design/dtoi_pkg.sv -----
// Shared types and constants of the decimal token parser.
package dtoi_pkg;

   localparam int MAX_DIGITS = 24;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] TWO_POW_63 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MUL_LIMIT  = 64'd922337203685477580;

   // Character classes.
   localparam logic [2:0] CLS_BLANK = 3'd0;
   localparam logic [2:0] CLS_EOF   = 3'd1;
   localparam logic [2:0] CLS_PLUS  = 3'd2;
   localparam logic [2:0] CLS_MINUS = 3'd3;
   localparam logic [2:0] CLS_DIGIT = 3'd4;
   localparam logic [2:0] CLS_OTHER = 3'd5;

   // Result status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_LONG    = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;

   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] digit;
   } item_type;

endpackage

// ----- design/dtoi_front.sv -----
// Front end: classifies each input byte into a token item.
module dtoi_front (
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   output dtoi_pkg::item_type item
);

   logic [7:0] sub_digit;

   assign sub_digit = req_tdata - 8'd48;

   // class of the byte; end of input wins over the byte
   always_comb begin
      item.digit = sub_digit[3:0];
      if (req_tlast) begin
         item.cls = dtoi_pkg::CLS_EOF;
      end else if (req_tdata inside {8'd32, [8'd9:8'd13]}) begin
         item.cls = dtoi_pkg::CLS_BLANK;
      end else if (req_tdata == 8'd43) begin
         item.cls = dtoi_pkg::CLS_PLUS;
      end else if (req_tdata == 8'd45) begin
         item.cls = dtoi_pkg::CLS_MINUS;
      end else if (req_tdata inside {[8'd48:8'd57]}) begin
         item.cls = dtoi_pkg::CLS_DIGIT;
      end else begin
         item.cls = dtoi_pkg::CLS_OTHER;
      end
   end

endmodule

// ----- design/dtoi_queue.sv -----
// Short queue of classified items between front and back end.
module dtoi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dtoi_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output dtoi_pkg::item_type pop_item
);

   dtoi_pkg::item_type                  slot_ff [dtoi_pkg::QUEUE_DEPTH];
   logic [dtoi_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [dtoi_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [dtoi_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full      = (count_ff == dtoi_pkg::QCNT_W'(dtoi_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dtoi_pkg::QPTR_W'(dtoi_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dtoi_pkg::QPTR_W'(dtoi_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/dtoi_back.sv -----
// Back end: token state machine, accumulator and result register.
`include "assert_macros.svh"

module dtoi_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  dtoi_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_value,
   output logic [2:0]         rsp_status
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_TOKEN   = 2'd1;
   localparam logic [1:0] PH_DISCARD = 2'd2;

   logic [1:0]                  phase_ff, phase_in;
   logic                        neg_ff, neg_in;
   logic [dtoi_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [63:0]                 mag_ff, mag_in;
   logic                        ovf_ff, ovf_in;
   logic                        out_valid_ff, out_valid_in;
   logic [63:0]                 out_value_ff, out_value_in;
   logic [2:0]                  out_status_ff, out_status_in;

   logic                        advance;
   logic                        in_token;
   logic                        tok_neg;
   logic [dtoi_pkg::CNT_W-1:0]  tok_cnt;
   logic [63:0]                 tok_mag;
   logic                        tok_ovf;
   logic [63:0]                 mag_x10;
   logic                        emit;
   logic [63:0]                 emit_value;
   logic [2:0]                  emit_status;

   assign advance  = !out_valid_ff || rsp_tready;
   assign item_pop = item_valid && advance;

   // token state seen by this item: cleared when a token starts
   assign in_token = (phase_ff == PH_TOKEN);
   assign tok_neg  = in_token ? neg_ff : 1'b0;
   assign tok_cnt  = in_token ? cnt_ff : '0;
   assign tok_mag  = in_token ? mag_ff : '0;
   assign tok_ovf  = in_token ? ovf_ff : 1'b0;

   // times ten as two shifted adds, plus the digit
   assign mag_x10 = {tok_mag[60:0], 3'b000} + {tok_mag[62:0], 1'b0}
                    + {60'd0, item.digit};

   // next state and result for one popped item
   always_comb begin
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      mag_in      = mag_ff;
      ovf_in      = ovf_ff;
      emit        = 1'b0;
      emit_value  = '0;
      emit_status = dtoi_pkg::ST_OK;
      if (item_pop) begin
         if (phase_ff == PH_DISCARD) begin
            if (item.cls == dtoi_pkg::CLS_EOF || item.cls == dtoi_pkg::CLS_BLANK) begin
               phase_in = PH_IDLE;
            end
         end else if (!in_token && item.cls == dtoi_pkg::CLS_EOF) begin
            // end of input while idle
            phase_in    = PH_IDLE;
            neg_in      = 1'b0;
            cnt_in      = '0;
            mag_in      = '0;
            ovf_in      = 1'b0;
            emit        = 1'b1;
            emit_status = dtoi_pkg::ST_EMPTY;
         end else if (!in_token && item.cls == dtoi_pkg::CLS_BLANK) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_TOKEN;
            neg_in   = tok_neg;
            cnt_in   = tok_cnt;
            mag_in   = tok_mag;
            ovf_in   = tok_ovf;
            if (item.cls == dtoi_pkg::CLS_EOF || item.cls == dtoi_pkg::CLS_BLANK) begin
               // token finished
               emit     = 1'b1;
               phase_in = PH_IDLE;
               neg_in   = 1'b0;
               cnt_in   = '0;
               mag_in   = '0;
               ovf_in   = 1'b0;
               if (tok_cnt == '0) begin
                  emit_status = dtoi_pkg::ST_EMPTY;
               end else if (tok_ovf || (!tok_neg && tok_mag == dtoi_pkg::TWO_POW_63)) begin
                  emit_status = dtoi_pkg::ST_RANGE;
                  emit_value  = tok_neg ? dtoi_pkg::TWO_POW_63
                                        : dtoi_pkg::TWO_POW_63 - 64'd1;
               end else begin
                  emit_value = tok_neg ? (64'd0 - tok_mag) : tok_mag;
               end
            end else if (tok_cnt >= dtoi_pkg::CNT_W'(dtoi_pkg::MAX_DIGITS)) begin
               emit        = 1'b1;
               emit_status = dtoi_pkg::ST_LONG;
               phase_in    = PH_DISCARD;
               neg_in      = 1'b0;
               cnt_in      = '0;
               mag_in      = '0;
               ovf_in      = 1'b0;
            end else begin
               case (item.cls)
                  dtoi_pkg::CLS_PLUS: begin
                  end
                  dtoi_pkg::CLS_MINUS: begin
                     neg_in = !tok_neg;
                  end
                  dtoi_pkg::CLS_DIGIT: begin
                     cnt_in = tok_cnt + 1'b1;
                     if (!tok_ovf) begin
                        if (tok_mag > dtoi_pkg::MUL_LIMIT) begin
                           ovf_in = 1'b1;
                        end else if (mag_x10 > dtoi_pkg::TWO_POW_63) begin
                           ovf_in = 1'b1;
                        end else begin
                           mag_in = mag_x10;
                        end
                     end
                  end
                  default: begin
                     emit        = 1'b1;
                     emit_status = dtoi_pkg::ST_INVALID;
                     phase_in    = PH_DISCARD;
                     neg_in      = 1'b0;
                     cnt_in      = '0;
                     mag_in      = '0;
                     ovf_in      = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_value_in  = emit_value;
         out_status_in = emit_status;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

   // checks
   `DTOI_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= dtoi_pkg::CNT_W'(dtoi_pkg::MAX_DIGITS))
   `DTOI_ASSERT(a_mag_bound, clock, reset, mag_ff <= dtoi_pkg::TWO_POW_63)
   `DTOI_ASSERT(a_clear_outside, clock, reset, (phase_ff != PH_TOKEN) |-> (cnt_ff == '0 && !ovf_ff && mag_ff == '0))
   `DTOI_NEVER(a_err_zero, clock, reset, out_valid_ff && (out_status_ff == dtoi_pkg::ST_INVALID || out_status_ff == dtoi_pkg::ST_EMPTY || out_status_ff == dtoi_pkg::ST_LONG) && out_value_ff != '0)
   `DTOI_ASSERT(a_hold_stall, clock, reset, (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_value_ff)))

endmodule

// ----- design/decimal_token_to_integer.sv -----
// Top level: decimal token parser, bytes in, signed 64-bit results out.
// rsp_tvalid rises once the byte that ends a token has passed the queue and the result register.
// Throughput: one byte per cycle while no result is held by rsp_tready low.
// A result held by rsp_tready low lets two bytes queue, then req_tready drops.
// Reset: synchronous, active high; empties the queue and result register and returns
// the parser to idle with a cleared token.
module decimal_token_to_integer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [63:0] value, [66:64] status, [71:67] zero
);

   dtoi_pkg::item_type front_item;
   dtoi_pkg::item_type back_item;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   logic [63:0]        rsp_value;
   logic [2:0]         rsp_status;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   dtoi_front u_front (
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .item      (front_item)
   );

   dtoi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (back_item)
   );

   dtoi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (back_item),
      .item_pop   (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {5'd0, rsp_status, rsp_value};

endmodule
